// ===== rtl/ate_pkg.sv =====
// shared types and constants of the affine transform engine
// no dependencies; used by ate_front, ate_back and the top level
`default_nettype none

package ate_pkg;

    // request kinds, coded as the mode field
    typedef enum logic [2:0] {
        OP_IDENT = 3'd0,
        OP_TRANS = 3'd1,
        OP_SCALE = 3'd2,
        OP_ROT   = 3'd3,
        OP_POINT = 3'd4
    } op_t;

    // one queued request
    typedef struct packed {
        op_t                op;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [15:0]        angle;
    } cmd_t;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [32:0] HALF_PI_Q30     = 33'sd1686629713;

    localparam logic signed [33:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd8,
        34'sd4,         34'sd2
    };

endpackage

`default_nettype wire

// ===== rtl/ate_front.sv =====
// front end: accepts input requests, drops unused modes, two-entry queue
// depends on ate_pkg
`default_nettype none

module ate_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,   // vec_x, vec_y, vec_z, angle
    input  wire logic [2:0]    s_tuser,   // mode
    output logic               q_valid,
    output ate_pkg::cmd_t      q_entry,
    input  wire logic          q_pop
);

    ate_pkg::cmd_t q_mem_reg [0:1];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          keep;
    logic          push;
    ate_pkg::cmd_t entry;

    always_comb begin
        unique case (s_tuser)
            ate_pkg::OP_IDENT, ate_pkg::OP_TRANS, ate_pkg::OP_SCALE,
            ate_pkg::OP_ROT, ate_pkg::OP_POINT: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign entry.op    = ate_pkg::op_t'(s_tuser);
    assign entry.vec_x = s_tdata[31:0];
    assign entry.vec_y = s_tdata[63:32];
    assign entry.vec_z = s_tdata[95:64];
    assign entry.angle = s_tdata[111:96];

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ate_back.sv =====
// back end: matrix state, shared multiplier, cordic and sequencer
// depends on ate_pkg
`default_nettype none

module ate_back #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire ate_pkg::cmd_t      q_entry,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    overflow
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [67:0] RND_HALF = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] SC_HALF  =
        (SH > 0) ? (34'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 34'sd0;
    localparam logic signed [67:0] SAT_MAX  = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN  = -68'sd2147483648;
    localparam logic signed [31:0] ONE_Q    = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_SCALE = 11'b00000000010,
        ST_ANG   = 11'b00000000100,
        ST_CORD  = 11'b00000001000,
        ST_SC    = 11'b00000010000,
        ST_NS    = 11'b00000100000,
        ST_RT    = 11'b00001000000,
        ST_LCOL  = 11'b00010000000,
        ST_MAC   = 11'b00100000000,
        ST_PT    = 11'b01000000000,
        ST_SPARE = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    ate_pkg::cmd_t      cmd_reg;
    logic signed [31:0] mat_reg [0:11];
    logic signed [31:0] rot_reg [0:8];
    logic signed [31:0] col_reg [0:2];
    logic signed [31:0] ns_reg  [0:2];
    logic signed [31:0] t1_reg, t_reg;
    logic signed [32:0] c_reg, s_reg, rc_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [65:0] prod_reg;
    logic signed [67:0] acc_reg;
    logic [4:0]         cnt_reg;
    logic [2:0]         ph_reg;
    logic [1:0]         i_reg, j_reg, k_reg;
    logic               out_valid_reg, ovf_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [3:0]         mat_idx;
    logic signed [31:0] mat_rd;
    logic [3:0]         rot_rd_idx, rot_wr_idx;
    logic [1:0]         kk, i_nxt;
    logic [23:0]        angle_ext;
    logic [1:0]         quad;
    logic signed [33:0] cq, sq;
    logic signed [67:0] prod_ext, acc_sum, pt_sum, rot_sum;
    logic signed [31:0] prod_sr;
    logic               go;

    function automatic logic signed [67:0] rnd(input logic signed [67:0] v);
        return (v + RND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic is_ovf(input logic signed [67:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic signed [31:0] vsel(input ate_pkg::cmd_t c,
                                                input logic [1:0] idx);
        case (idx)
            2'd0:    return c.vec_x;
            2'd1:    return c.vec_y;
            default: return c.vec_z;
        endcase
    endfunction

    assign angle_ext  = 24'(cmd_reg.angle);
    assign quad       = angle_ext[ANGLE_BITS-1 -: 2];
    assign mat_rd     = mat_reg[mat_idx];
    assign rot_rd_idx = 4'(i_reg) * 4'd3 + 4'(k_reg);
    assign rot_wr_idx = 4'(i_reg) * 4'd3 + 4'(j_reg);
    assign kk         = 2'd3 - i_reg - j_reg;
    assign i_nxt      = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
    assign prod_ext   = 68'(prod_reg);
    assign prod_sr    = sat32(rnd(prod_ext));
    assign acc_sum    = (k_reg == 2'd0) ? prod_ext : acc_reg + prod_ext;
    assign pt_sum     = rnd(acc_reg) + 68'(mat_rd);

    // a point request waits until the result register is free
    assign go    = (state_reg == ST_IDLE) && q_valid &&
                   ((q_entry.op != ate_pkg::OP_POINT) || !out_valid_reg);
    assign q_pop = go;

    always_comb begin
        case (quad)
            2'd0:    begin cq = x_reg;  sq = y_reg;  end
            2'd1:    begin cq = -y_reg; sq = x_reg;  end
            2'd2:    begin cq = -x_reg; sq = -y_reg; end
            default: begin cq = y_reg;  sq = -x_reg; end
        endcase
    end

    always_comb begin
        if (j_reg == i_reg) begin
            rot_sum = 68'(c_reg) + 68'(t_reg);
        end else if (j_reg == i_nxt) begin
            rot_sum = 68'(t_reg) - 68'(ns_reg[kk]);
        end else begin
            rot_sum = 68'(t_reg) + 68'(ns_reg[kk]);
        end
    end

    // matrix read address and multiplier operands
    always_comb begin
        mat_idx = 4'd0;
        mul_a   = 33'sd0;
        mul_b   = 33'sd0;
        unique case (state_reg)
            ST_SCALE: begin
                mat_idx = cnt_reg[3:0];
                mul_a   = 33'(mat_rd);
                mul_b   = 33'(vsel(cmd_reg, cnt_reg[3:2]));
            end
            ST_ANG: begin
                mul_a = $signed(33'(angle_ext[ANGLE_BITS-3:0]));
                mul_b = ate_pkg::HALF_PI_Q30;
            end
            ST_NS: begin
                mul_a = 33'(vsel(cmd_reg, k_reg));
                mul_b = s_reg;
            end
            ST_RT: begin
                if (ph_reg == 3'd2) begin
                    mul_a = 33'(t1_reg);
                    mul_b = rc_reg;
                end else begin
                    mul_a = 33'(vsel(cmd_reg, i_reg));
                    mul_b = 33'(vsel(cmd_reg, j_reg));
                end
            end
            ST_LCOL: begin
                mat_idx = {k_reg, j_reg};
            end
            ST_MAC: begin
                mul_a = 33'(rot_reg[rot_rd_idx]);
                mul_b = 33'(col_reg[k_reg]);
            end
            ST_PT: begin
                mat_idx = (ph_reg == 3'd2) ? {i_reg, 2'd3} : {i_reg, k_reg};
                mul_a   = 33'(mat_rd);
                mul_b   = 33'(vsel(cmd_reg, k_reg));
            end
            default: begin
                mat_idx = 4'd0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    case (q_entry.op)
                        ate_pkg::OP_SCALE: state_next = ST_SCALE;
                        ate_pkg::OP_ROT:   state_next = ST_ANG;
                        ate_pkg::OP_POINT: state_next = ST_PT;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: begin
                if (ph_reg == 3'd1 && cnt_reg == 5'd11) state_next = ST_IDLE;
            end
            ST_ANG: begin
                if (ph_reg == 3'd1) state_next = ST_CORD;
            end
            ST_CORD: begin
                if (cnt_reg == 5'(ate_pkg::CORDIC_STEPS - 1)) state_next = ST_SC;
            end
            ST_SC:   state_next = ST_NS;
            ST_NS: begin
                if (ph_reg == 3'd1 && k_reg == 2'd2) state_next = ST_RT;
            end
            ST_RT: begin
                if (ph_reg == 3'd4 && i_reg == 2'd2 && j_reg == 2'd2) begin
                    state_next = ST_LCOL;
                end
            end
            ST_LCOL: begin
                if (k_reg == 2'd2) state_next = ST_MAC;
            end
            ST_MAC: begin
                if (ph_reg == 3'd2 && i_reg == 2'd2) begin
                    state_next = (j_reg == 2'd3) ? ST_IDLE : ST_LCOL;
                end
            end
            ST_PT: begin
                if (ph_reg == 3'd2 && i_reg == 2'd2) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
            ph_reg        <= 3'd0;
            i_reg         <= 2'd0;
            j_reg         <= 2'd0;
            k_reg         <= 2'd0;
            for (int e = 0; e < 12; e++) begin
                mat_reg[e] <= (e % 5 == 0) ? ONE_Q : 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            // result raised on the last row of a point, dropped once taken
            if (state_reg == ST_PT && ph_reg == 3'd2 && i_reg == 2'd2) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= 5'd0;
                    ph_reg  <= 3'd0;
                    i_reg   <= 2'd0;
                    j_reg   <= 2'd0;
                    k_reg   <= 2'd0;
                    if (go) begin
                        cmd_reg <= q_entry;
                        case (q_entry.op)
                            ate_pkg::OP_IDENT: begin
                                for (int e = 0; e < 12; e++) begin
                                    mat_reg[e] <= (e % 5 == 0) ? ONE_Q : 32'sd0;
                                end
                            end
                            ate_pkg::OP_TRANS: begin
                                mat_reg[3]  <= sat32(68'(mat_reg[3]) + 68'(q_entry.vec_x));
                                mat_reg[7]  <= sat32(68'(mat_reg[7]) + 68'(q_entry.vec_y));
                                mat_reg[11] <= sat32(68'(mat_reg[11]) + 68'(q_entry.vec_z));
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCALE: begin
                    if (ph_reg == 3'd0) begin
                        ph_reg <= 3'd1;
                    end else begin
                        mat_reg[cnt_reg[3:0]] <= prod_sr;
                        cnt_reg <= cnt_reg + 5'd1;
                        ph_reg  <= 3'd0;
                    end
                end
                ST_ANG: begin
                    if (ph_reg == 3'd0) begin
                        ph_reg <= 3'd1;
                    end else begin
                        z_reg   <= 34'(prod_reg >>> (ANGLE_BITS - 2));
                        x_reg   <= ate_pkg::CORDIC_GAIN_INV;
                        y_reg   <= 34'sd0;
                        cnt_reg <= 5'd0;
                        ph_reg  <= 3'd0;
                    end
                end
                ST_CORD: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - (y_reg >>> cnt_reg);
                        y_reg <= y_reg + (x_reg >>> cnt_reg);
                        z_reg <= z_reg - ate_pkg::ATAN_Q30[cnt_reg];
                    end else begin
                        x_reg <= x_reg + (y_reg >>> cnt_reg);
                        y_reg <= y_reg - (x_reg >>> cnt_reg);
                        z_reg <= z_reg + ate_pkg::ATAN_Q30[cnt_reg];
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ST_SC: begin
                    c_reg <= 33'((cq + SC_HALF) >>> SH);
                    s_reg <= 33'((sq + SC_HALF) >>> SH);
                    k_reg <= 2'd0;
                end
                ST_NS: begin
                    if (ph_reg == 3'd0) begin
                        ph_reg <= 3'd1;
                    end else begin
                        ns_reg[k_reg] <= prod_sr;
                        rc_reg <= 33'(34'(ONE_Q) - 34'(c_reg));
                        k_reg  <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        ph_reg <= 3'd0;
                    end
                end
                ST_RT: begin
                    case (ph_reg)
                        3'd1:    t1_reg <= prod_sr;
                        3'd3:    t_reg  <= prod_sr;
                        3'd4: begin
                            rot_reg[rot_wr_idx] <= sat32(rot_sum);
                            if (j_reg == 2'd2) begin
                                j_reg <= 2'd0;
                                i_reg <= i_nxt;
                            end else begin
                                j_reg <= j_reg + 2'd1;
                            end
                        end
                        default: t1_reg <= t1_reg;
                    endcase
                    ph_reg <= (ph_reg == 3'd4) ? 3'd0 : ph_reg + 3'd1;
                end
                ST_LCOL: begin
                    col_reg[k_reg] <= mat_rd;
                    k_reg  <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    i_reg  <= 2'd0;
                    ph_reg <= 3'd0;
                end
                ST_MAC: begin
                    case (ph_reg)
                        3'd0: ph_reg <= 3'd1;
                        3'd1: begin
                            acc_reg <= acc_sum;
                            if (k_reg == 2'd2) begin
                                ph_reg <= 3'd2;
                            end else begin
                                k_reg  <= k_reg + 2'd1;
                                ph_reg <= 3'd0;
                            end
                        end
                        default: begin
                            mat_reg[{i_reg, j_reg}] <= sat32(rnd(acc_reg));
                            k_reg  <= 2'd0;
                            ph_reg <= 3'd0;
                            i_reg  <= i_nxt;
                            if (i_reg == 2'd2) begin
                                j_reg <= j_reg + 2'd1;
                            end
                        end
                    endcase
                end
                ST_PT: begin
                    case (ph_reg)
                        3'd0: ph_reg <= 3'd1;
                        3'd1: begin
                            acc_reg <= acc_sum;
                            if (k_reg == 2'd2) begin
                                ph_reg <= 3'd2;
                            end else begin
                                k_reg  <= k_reg + 2'd1;
                                ph_reg <= 3'd0;
                            end
                        end
                        default: begin
                            case (i_reg)
                                2'd0:    out_x_reg <= sat32(pt_sum);
                                2'd1:    out_y_reg <= sat32(pt_sum);
                                default: out_z_reg <= sat32(pt_sum);
                            endcase
                            ovf_reg <= is_ovf(pt_sum) || ((i_reg != 2'd0) && ovf_reg);
                            i_reg  <= i_nxt;
                            k_reg  <= 2'd0;
                            ph_reg <= 3'd0;
                        end
                    endcase
                end
                default: begin
                    ph_reg <= 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign m_tvalid = out_valid_reg;
    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_z    = out_z_reg;
    assign overflow = ovf_reg;

    // point requests only start with the result register empty
    a_point_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && q_entry.op == ate_pkg::OP_POINT) |-> !out_valid_reg)
        else $error("point started while result pending");

    // queue is popped only from idle
    a_pop_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped outside idle");

    // cordic never runs past its last table step
    a_cordic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (cnt_reg < 5'(ate_pkg::CORDIC_STEPS)))
        else $error("cordic step count out of range");

    // a result is raised only at the end of a point sequence
    a_result_from_point: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PT))
        else $error("result raised outside point sequence");

endmodule

`default_nettype wire

// ===== rtl/affine_transform_engine.sv =====
// top level of the affine transform engine: front queue plus back end
// depends on ate_pkg, ate_front and ate_back
`default_nettype none

// Keeps a 3x4 affine matrix in signed fixed point (FRAC_BITS fraction bits,
// bottom row implied 0,0,0,1), reset to identity. Each request on the s_
// channel carries a mode in s_tuser: identity, translate, per-row scale,
// rotate about a unit axis by an angle given as a fraction of a full turn,
// or transform a point. Only point requests produce a result on the m_
// channel, the transformed point with an overflow flag when any coordinate
// saturated; unused modes are taken and dropped. Requests land in a
// two-entry queue so the input keeps moving while the back end works and
// while a result waits to be taken. The back end has one shared 33x33
// multiplier with a registered product and a 30-step cordic loop; identity
// and translate are applied as the request is taken from the queue, and a
// rotation runs the cordic loop, the rotation terms and the matrix product
// in turn after its setup. A point request waits in the queue until the
// previous result has been taken.
module affine_transform_engine #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // request channel
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,   // vec_x, vec_y, vec_z, angle
    input  wire logic [2:0]    s_tuser,   // mode
    // result channel
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [95:0]        m_tdata,   // out_x, out_y, out_z
    output logic [0:0]         m_tuser    // overflow
);

    logic               q_valid;
    logic               q_pop;
    ate_pkg::cmd_t      q_entry;
    logic signed [31:0] out_x, out_y, out_z;
    logic               overflow;

    // request intake and classification
    ate_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // matrix state and arithmetic
    ate_back #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z),
        .overflow (overflow)
    );

    // result packing, x in the low word
    assign m_tdata = {out_z, out_y, out_x};
    assign m_tuser = overflow;

endmodule

`default_nettype wire
